>>> rtl/rfve_pkg.sv
// Shared types, constants and helpers for the stream-reset frame varint encoder.
package rfve_pkg;

  // Frame type byte that opens every encoded frame
  localparam logic [7:0] FRAME_TYPE = 8'h24;

  // Upper bounds of the 1, 2, 4 and 8 byte varint ranges
  localparam logic [63:0] MAX_LEN1 = 64'd63;
  localparam logic [63:0] MAX_LEN2 = 64'd16383;
  localparam logic [63:0] MAX_LEN4 = 64'd1073741823;
  localparam logic [63:0] MAX_LEN8 = 64'd4611686018427387903;

  // Number of values in one frame
  localparam int NUM_VALUES = 4;

  // Register map: word index taken from paddr[2]
  localparam logic REG_OUT_CAPACITY = 1'b0;
  localparam logic [7:0] CAPACITY_RESET = 8'd64;

  // Varint length codes (the 2-bit prefix)
  localparam logic [1:0] CODE_LEN1 = 2'd0;
  localparam logic [1:0] CODE_LEN2 = 2'd1;
  localparam logic [1:0] CODE_LEN4 = 2'd2;
  localparam logic [1:0] CODE_LEN8 = 2'd3;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RELIABLE = 2'd1,
    STAT_NO_SPACE = 2'd2,
    STAT_OVERFLOW = 2'd3
  } stat_t;

  // Per-lane classification of one value
  typedef struct packed {
    logic       ovf;
    logic [1:0] code;
    logic [3:0] nbytes;
  } lane_t;

  // Merged frame verdict
  typedef struct packed {
    stat_t           status;
    logic [5:0]      total;
    logic [3:0][1:0] code;
  } merge_t;

  // Index of the most significant byte for a length code
  function automatic logic [2:0] msb_index(input logic [1:0] code);
    logic [2:0] idx;
    case (code)
      CODE_LEN1: idx = 3'd0;
      CODE_LEN2: idx = 3'd1;
      CODE_LEN4: idx = 3'd3;
      default:   idx = 3'd7;
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/rfve_lane.sv
// One lane: classifies a 64-bit value into its varint length.
module rfve_lane (
  input  logic [63:0]   value,
  output rfve_pkg::lane_t res
);
  import rfve_pkg::*;

  // Pick the shortest encoding that holds the value
  always_comb begin
    res = '0;
    if (value <= MAX_LEN1) begin
      res.code   = CODE_LEN1;
      res.nbytes = 4'd1;
    end else if (value <= MAX_LEN2) begin
      res.code   = CODE_LEN2;
      res.nbytes = 4'd2;
    end else if (value <= MAX_LEN4) begin
      res.code   = CODE_LEN4;
      res.nbytes = 4'd4;
    end else if (value <= MAX_LEN8) begin
      res.code   = CODE_LEN8;
      res.nbytes = 4'd8;
    end else begin
      res.ovf    = 1'b1;
      res.code   = CODE_LEN8;
      res.nbytes = 4'd0;
    end
  end

endmodule

>>> rtl/rfve_merge.sv
// Merge stage: sums lane lengths and registers the frame verdict.
module rfve_merge (
  input  logic                 clk,
  input  rfve_pkg::lane_t      lanes [4],
  input  logic [63:0]          final_bytes,
  input  logic [63:0]          reliable_bytes,
  input  logic [7:0]           capacity,
  output rfve_pkg::merge_t     verdict_r
);
  import rfve_pkg::*;

  merge_t     verdict_nxt;
  logic [5:0] total;
  logic       any_ovf;

  // Add up the frame length; overflowed values count as zero bytes
  always_comb begin
    total = 6'd1 + {2'b00, lanes[0].nbytes} + {2'b00, lanes[1].nbytes}
                 + {2'b00, lanes[2].nbytes} + {2'b00, lanes[3].nbytes};
    any_ovf = lanes[0].ovf | lanes[1].ovf | lanes[2].ovf | lanes[3].ovf;
  end

  // Apply the error checks in priority order
  always_comb begin
    verdict_nxt.total = total;
    for (int i = 0; i < NUM_VALUES; i++) begin
      verdict_nxt.code[i] = lanes[i].code;
    end
    if (reliable_bytes > final_bytes) begin
      verdict_nxt.status = STAT_RELIABLE;
    end else if ({2'b00, total} > capacity) begin
      verdict_nxt.status = STAT_NO_SPACE;
    end else if (any_ovf) begin
      verdict_nxt.status = STAT_OVERFLOW;
    end else begin
      verdict_nxt.status = STAT_OK;
    end
  end

  // Hold the verdict for the byte sequencer
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

endmodule

>>> rtl/reset_frame_varint_encoder.sv
// Top level: stream-reset frame encoder with APB register and byte stream output.
// The lanes classify and the merge stage registers the verdict in ST_CHECK;
// ST_EMIT then loads the words into the output register, and a new frame is
// taken only in idle. A frame is one word on an error and 5..33 bytes otherwise,
// emitted by the byte-wide output sequencer one word a cycle unless stalled.
// Reset (rst_n low, synchronous): sequencer idle, output empty, capacity 64.
module reset_frame_varint_encoder (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: stream_ident[63:0], app_error[127:64], final_bytes[191:128],
  //           reliable_bytes[255:192]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,
  // out_tdata: out_byte[7:0], frame_length[13:8], zero[15:14]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,
  output logic         out_tlast,
  // out_tuser: status[1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import rfve_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t          state_r;
  logic [7:0]      cap_r;
  logic [3:0][63:0] held_r;
  logic            hdr_r;
  logic [1:0]      vi_r;
  logic [2:0]      bi_r;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic [5:0]      out_len_r;
  logic            out_last_r;
  stat_t           out_stat_r;

  lane_t           lanes [4];
  merge_t          verdict_r;
  logic            emit_ok;
  logic            load_word;
  logic            cfg_wr;
  logic [1:0]      cur_code;
  logic [2:0]      cur_msb;
  logic [2:0]      byte_idx;
  logic [7:0]      cur_byte;
  logic            val_done;

  // Classify the four held values side by side
  for (genvar g = 0; g < NUM_VALUES; g++) begin : g_lane
    rfve_lane u_lane (
      .value (held_r[g]),
      .res   (lanes[g])
    );
  end

  rfve_merge u_merge (
    .clk            (clk),
    .lanes          (lanes),
    .final_bytes    (held_r[2]),
    .reliable_bytes (held_r[3]),
    .capacity       (cap_r),
    .verdict_r      (verdict_r)
  );

  // Select the current byte, big-endian, with the length prefix on the first
  always_comb begin
    cur_code = verdict_r.code[vi_r];
    cur_msb  = msb_index(cur_code);
    byte_idx = cur_msb - bi_r;
    cur_byte = held_r[vi_r][{byte_idx, 3'b000} +: 8];
    if (bi_r == 3'd0) begin
      cur_byte = cur_byte | {cur_code, 6'b000000};
    end
    val_done = (bi_r == cur_msb);
  end

  assign emit_ok    = !out_valid_r || out_tready;
  assign load_word  = (state_r == ST_EMIT) && emit_ok;
  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_OUT_CAPACITY) ? {24'd0, cap_r} : 32'd0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAPACITY_RESET;
      hdr_r       <= 1'b0;
      vi_r        <= 2'd0;
      bi_r        <= 3'd0;
    end else begin
      // drop a word once taken, unless the next one is loaded in its place
      if (out_valid_r && out_tready && !load_word) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && (cfg_paddr[2] == REG_OUT_CAPACITY)) begin
        cap_r <= cfg_pwdata[7:0];
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            held_r  <= in_tdata;
            hdr_r   <= 1'b1;
            vi_r    <= 2'd0;
            bi_r    <= 3'd0;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_stat_r  <= verdict_r.status;
            if (verdict_r.status != STAT_OK) begin
              // single error word, no bytes
              out_byte_r <= 8'd0;
              out_len_r  <= 6'd0;
              out_last_r <= 1'b1;
              state_r    <= ST_IDLE;
            end else if (hdr_r) begin
              out_byte_r <= FRAME_TYPE;
              out_len_r  <= verdict_r.total;
              out_last_r <= 1'b0;
              hdr_r      <= 1'b0;
            end else begin
              out_byte_r <= cur_byte;
              out_len_r  <= verdict_r.total;
              out_last_r <= val_done && (vi_r == 2'd3);
              if (val_done) begin
                bi_r <= 3'd0;
                vi_r <= vi_r + 2'd1;
                if (vi_r == 2'd3) begin
                  state_r <= ST_IDLE;
                end
              end else begin
                bi_r <= bi_r + 3'd1;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_reset_frame_varint_encoder.sv
// Self-checking testbench for the stream-reset frame varint encoder.
module tb_reset_frame_varint_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rfve_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES = 4;
  localparam int PHASE_FRAMES = 20;
  localparam int NUM_ROWS = 21;
  localparam logic [2:0] CAP_ADDR = {REG_OUT_CAPACITY, 2'b00};
  localparam logic [63:0] TWO_POW_62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // One input word; stream_ident lands in the lowest bits of in_tdata
  typedef struct packed {
    logic [63:0] rel;
    logic [63:0] fin;
    logic [63:0] err;
    logic [63:0] sid;
  } frame_t;

  // One output word as the checker compares it
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last;
    stat_t      status;
    logic [5:0] flen;
  } frame_word_t;

  // Directed row: capacity to run under, frame, and an optional typed-in error
  typedef struct packed {
    logic [7:0]  cap;
    logic [63:0] sid;
    logic [63:0] err;
    logic [63:0] fin;
    logic [63:0] rel;
    logic        typed;
    stat_t       want;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [255:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tlast;
  logic [1:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  frame_word_t pending_words[$];
  frame_word_t head_word;
  logic [7:0] capacity_setting = CAPACITY_RESET;
  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  vector_row_t directed_rows [NUM_ROWS] = '{
    // all zero under the reset capacity, then the varint length boundaries
    '{8'd64, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, STAT_OK},
    '{8'd64, MAX_LEN1, MAX_LEN1 + 64'd1, MAX_LEN2 + 64'd1, MAX_LEN2, 1'b0, STAT_OK},
    '{8'd64, MAX_LEN4, MAX_LEN4 + 64'd1, MAX_LEN8, MAX_LEN8, 1'b0, STAT_OK},
    '{8'd64, MAX_LEN8, MAX_LEN8, MAX_LEN8, MAX_LEN8, 1'b0, STAT_OK},
    // reliable size above final size, also ahead of overflow
    '{8'd64, 64'd0, 64'd0, 64'd0, 64'd1, 1'b1, STAT_RELIABLE},
    '{8'd64, ALL_ONES, ALL_ONES, ALL_ONES - 64'd1, ALL_ONES, 1'b1, STAT_RELIABLE},
    // values at or above 2^62
    '{8'd64, TWO_POW_62, 64'd0, 64'd0, 64'd0, 1'b1, STAT_OVERFLOW},
    '{8'd64, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, STAT_OVERFLOW},
    '{8'd64, 64'd0, TWO_POW_62, TWO_POW_62, TWO_POW_62, 1'b1, STAT_OVERFLOW},
    // tight capacity: exact fit, no space, overflowed fields counted as zero bytes
    '{8'd5, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, STAT_OK},
    '{8'd5, 64'd64, 64'd0, 64'd0, 64'd0, 1'b1, STAT_NO_SPACE},
    '{8'd5, TWO_POW_62, MAX_LEN2, 64'd0, 64'd0, 1'b1, STAT_OVERFLOW},
    '{8'd5, TWO_POW_62, 64'd1 << 20, 64'd0, 64'd0, 1'b1, STAT_NO_SPACE},
    '{8'd5, 64'd64, 64'd0, 64'd5, 64'd6, 1'b1, STAT_RELIABLE},
    // zero capacity never fits
    '{8'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, STAT_NO_SPACE},
    '{8'd0, ALL_ONES, 64'd0, 64'd0, 64'd0, 1'b1, STAT_NO_SPACE},
    // widest capacity, then the longest frame against 33 and 32 bytes
    '{8'd255, MAX_LEN8, MAX_LEN8, MAX_LEN8, MAX_LEN8, 1'b0, STAT_OK},
    '{8'd255, MAX_LEN2, MAX_LEN4, MAX_LEN8, 64'd0, 1'b0, STAT_OK},
    '{8'd33, MAX_LEN8, MAX_LEN8, MAX_LEN8, MAX_LEN8, 1'b0, STAT_OK},
    '{8'd32, MAX_LEN8, MAX_LEN8, MAX_LEN8, MAX_LEN8, 1'b1, STAT_NO_SPACE},
    '{8'd32, MAX_LEN8, MAX_LEN4, MAX_LEN4, MAX_LEN2, 1'b0, STAT_OK}
  };

  reset_frame_varint_encoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Encoded varint length, zero once the value reaches 2^62
  function automatic int varint_len(input logic [63:0] v);
    if (v <= MAX_LEN1) return 1;
    if (v <= MAX_LEN2) return 2;
    if (v <= MAX_LEN4) return 4;
    if (v <= MAX_LEN8) return 8;
    return 0;
  endfunction

  // Work out the output words of one frame and queue them
  function automatic void encode_reset_frame(input frame_t f);
    logic [63:0] vals [4];
    int lens [4];
    int total;
    bit ovf;
    stat_t st;
    logic [1:0] code;
    logic [7:0] b8;
    logic [5:0] flen;
    vals[0] = f.sid;
    vals[1] = f.err;
    vals[2] = f.fin;
    vals[3] = f.rel;
    total = 1;
    ovf = 1'b0;
    for (int i = 0; i < NUM_VALUES; i++) begin
      lens[i] = varint_len(vals[i]);
      if (lens[i] == 0) ovf = 1'b1;
      total += lens[i];
    end
    if (f.rel > f.fin) st = STAT_RELIABLE;
    else if (total > int'(capacity_setting)) st = STAT_NO_SPACE;
    else if (ovf) st = STAT_OVERFLOW;
    else st = STAT_OK;
    if (st != STAT_OK) begin
      pending_words.push_back('{8'h00, 1'b1, st, 6'd0});
      return;
    end
    flen = total[5:0];
    pending_words.push_back('{FRAME_TYPE, 1'b0, STAT_OK, flen});
    for (int i = 0; i < NUM_VALUES; i++) begin
      case (lens[i])
        1: code = CODE_LEN1;
        2: code = CODE_LEN2;
        4: code = CODE_LEN4;
        default: code = CODE_LEN8;
      endcase
      // big-endian, length prefix in the top two bits of the first byte
      for (int k = 0; k < lens[i]; k++) begin
        b8 = 8'(vals[i] >> (8 * (lens[i] - 1 - k)));
        if (k == 0) b8 = b8 | {code, 6'b0};
        pending_words.push_back('{b8, (i == NUM_VALUES - 1) && (k == lens[i] - 1),
                                  STAT_OK, flen});
      end
    end
  endfunction

  // Random value, weighted across the four varint lengths with rare overflow
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int r;
    r = $urandom_range(0, 19);
    v = {$urandom, $urandom};
    if (r < 6) v = 64'($urandom_range(0, 63));
    else if (r < 10) v = 64'($urandom_range(64, 16383));
    else if (r < 14) v = 64'($urandom_range(16384, 1073741823));
    else if (r < 19) begin
      v[63:62] = 2'b00;
      if (v <= MAX_LEN4) v[61 - $urandom_range(0, 30)] = 1'b1;
    end else if (v[63:62] == 2'b00) begin
      v[62 + $urandom_range(0, 1)] = 1'b1;
    end
    return v;
  endfunction

  // Mostly well-formed frames (reliable within final), the rest unordered
  function automatic frame_t random_frame();
    frame_t f;
    logic [63:0] a, b;
    f.sid = random_value();
    f.err = random_value();
    a = random_value();
    b = random_value();
    if ($urandom_range(0, 4) != 0) begin
      f.fin = (a >= b) ? a : b;
      f.rel = (a >= b) ? b : a;
    end else begin
      f.fin = a;
      f.rel = b;
    end
    return f;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Offer one frame word and hold it until the handshake
  task automatic send_frame(input frame_t f);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= f;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; the register takes the value on the access edge
  task automatic program_capacity(input logic [7:0] cap);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CAP_ADDR;
    cfg_pwdata <= {24'd0, cap};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    capacity_setting = cap;
  endtask

  // Receiver: random stalls, none while calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= calm ? 0 : gap_len();
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("word with nothing expected: tdata %h last %b status %0d",
                                out_tdata, out_tlast, out_tuser));
      end else begin
        head_word = pending_words.pop_front();
        if (out_tdata[7:0] != head_word.wire_byte)
          note_mismatch($sformatf("byte %h, expected %h", out_tdata[7:0],
                                  head_word.wire_byte));
        if (out_tdata[13:8] != head_word.flen)
          note_mismatch($sformatf("frame_length %0d, expected %0d", out_tdata[13:8],
                                  head_word.flen));
        if (out_tdata[15:14] != 2'b00)
          note_mismatch($sformatf("tdata pad bits %b", out_tdata[15:14]));
        if (out_tlast != head_word.last)
          note_mismatch($sformatf("last %b, expected %b", out_tlast, head_word.last));
        if (out_tuser != head_word.status)
          note_mismatch($sformatf("status %0d, expected %0d", out_tuser,
                                  head_word.status));
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("reset_frame_varint_encoder regression: fail");
      $finish;
    end
  end

  initial begin
    frame_t f;
    logic [7:0] next_cap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, reprogramming capacity when a row asks for another one
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].cap != capacity_setting) begin
        settle_idle();
        program_capacity(directed_rows[r].cap);
      end
      f = '{directed_rows[r].rel, directed_rows[r].fin, directed_rows[r].err,
            directed_rows[r].sid};
      send_frame(f);
      if (directed_rows[r].typed) pending_words.push_back('{8'h00, 1'b1, directed_rows[r].want,
                                                            6'd0});
      else encode_reset_frame(f);
    end

    // Random phases, each under a fresh capacity
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      case (p)
        0: next_cap = 8'($urandom_range(20, 40));
        1: next_cap = 8'($urandom_range(5, 33));
        2: next_cap = 8'($urandom_range(0, 255));
        default: next_cap = 8'd255;
      endcase
      program_capacity(next_cap);
      calm = (p == 1);
      for (int k = 0; k < PHASE_FRAMES; k++) begin
        f = random_frame();
        send_frame(f);
        encode_reset_frame(f);
      end
    end

    calm = 1'b0;
    settle_idle();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("reset_frame_varint_encoder regression: pass");
    else $display("reset_frame_varint_encoder regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/rfve_pkg.sv
rtl/rfve_lane.sv
rtl/rfve_merge.sv
rtl/reset_frame_varint_encoder.sv
sim/tb_reset_frame_varint_encoder.sv
